>>> src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SDLP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sdlp assertion failed");

// next-cycle implication, disabled during reset
`define SDLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sdlp assertion failed");

`endif

>>> src/sdlp_pkg.sv
// shared constants for the signed decimal line parser
`default_nettype none

package sdlp_pkg;

	// parameter defaults
	localparam int MAX_FIELDS_DEF = 16;
	localparam int VALUE_BITS_DEF = 32;

	// fixed field widths
	localparam int LIMIT_W = 5;
	localparam int INDEX_W = 4;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd4;

	// character codes
	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_PLUS    = 8'd43;
	localparam logic [7:0] CH_MINUS   = 8'd45;
	localparam logic [7:0] CH_ZERO    = 8'd48;
	localparam logic [7:0] CH_NINE    = 8'd57;

endpackage

`default_nettype wire

>>> src/signed_decimal_line_parser.sv
// Signed decimal line parser: ASCII bytes in, signed field values out.
//
// Input channel: in_valid/in_ready carry one rx_byte per word. A line ends
// at newline; each '+' or '-' opens a field whose value is the digit run
// just before the next sign or newline (zero if there is none).
// Output channel: out_valid/out_ready carry one word per field closed by a
// sign within the field limit, plus one per newline, holding its field.
// Bytes that close nothing (digits, other characters) give no word.
// Configuration: cfg_wr_en/cfg_wr_data write the field limit (reset 4);
// write it only while the parser holds no pending byte or result.
// Throughput: one byte per cycle unless a result waits on out_ready (see
// Stall). An accepted byte loads the input register; its result loads the
// result register once that register is free; the per-byte update is one
// multiply-by-ten-plus-digit with its clamp.
// Reset: all line state clears, both channels go empty, limit returns to 4.
// Stall: while a result waits on out_ready the input register still drains
// bytes that give no result; a byte that would give one holds in_ready low.
`default_nettype none

module signed_decimal_line_parser #(
	parameter int MAX_FIELDS = sdlp_pkg::MAX_FIELDS_DEF,
	parameter int VALUE_BITS = sdlp_pkg::VALUE_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_wr_en,
	input  wire [sdlp_pkg::LIMIT_W-1:0]      cfg_wr_data,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire [7:0]                        rx_byte,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic signed [VALUE_BITS-1:0]     field_value,
	output logic [sdlp_pkg::INDEX_W-1:0]     field_index,
	output logic                             field_present,
	output logic                             last_in_line,
	output logic                             fields_dropped,
	output logic                             value_saturated
);
	import sdlp_pkg::*;

	localparam int MAG_W = VALUE_BITS - 1;
	localparam int CNT_W = $clog2(MAX_FIELDS + 2);
	localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam int SUM_W = MAG_W + 4;
	localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(MAX_FIELDS + 1);
	localparam logic [CMP_W-1:0] MAX_LIM = CMP_W'(MAX_FIELDS);

	// configuration register
	logic [LIMIT_W-1:0] field_limit_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// line state
	logic [MAG_W-1:0] mag_q;
	logic             neg_q;
	logic             open_q;
	logic [CNT_W-1:0] count_q;
	logic             clamp_q;
	logic             ovf_q;

	// next line state and result
	logic [MAG_W-1:0]   mag_n;
	logic               neg_n;
	logic               open_n;
	logic [CNT_W-1:0]   count_n;
	logic               clamp_n;
	logic               ovf_n;
	logic               res_valid;
	logic               res_present;
	logic               res_last;
	logic               res_dropped;
	logic               res_sat;
	logic [VALUE_BITS-1:0] res_value;
	logic [INDEX_W-1:0] res_index;

	// decode and helpers
	logic               is_nl;
	logic               is_sign;
	logic               is_digit;
	logic [CMP_W-1:0]   limit_ext;
	logic [CMP_W-1:0]   eff_lim;
	logic [CMP_W-1:0]   count_ext;
	logic [CMP_W-1:0]   cnt_inc_ext;
	logic [CMP_W-1:0]   idx_full;
	logic [CNT_W-1:0]   cnt_inc;
	logic               kept;
	logic [SUM_W-1:0]   mag_sum;
	logic               mag_clamp;
	logic [VALUE_BITS-1:0] mag_ext;
	logic [VALUE_BITS-1:0] signed_val;
	logic               out_free;
	logic               fire;

	// handshake: output register frees when empty or taken
	assign out_free = !out_valid || out_ready;
	assign fire     = valid_s1 && (out_free || !res_valid);
	assign in_ready = !valid_s1 || fire;

	// byte classes
	assign is_nl    = (byte_s1 == CH_NEWLINE);
	assign is_sign  = (byte_s1 == CH_PLUS) || (byte_s1 == CH_MINUS);
	assign is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);

	// effective limit and field position checks
	assign limit_ext   = CMP_W'(field_limit_q);
	assign eff_lim     = (limit_ext > MAX_LIM) ? MAX_LIM : limit_ext;
	assign count_ext   = CMP_W'(count_q);
	assign kept        = open_q && (count_q != '0) && (count_ext <= eff_lim);
	assign cnt_inc     = (count_q < CNT_TOP) ? count_q + CNT_W'(1) : count_q;
	assign cnt_inc_ext = CMP_W'(cnt_inc);
	assign idx_full    = count_ext - CMP_W'(1);

	// digit accumulate: mag*10 + d, clamped at the largest magnitude
	assign mag_sum   = (SUM_W'(mag_q) << 3) + (SUM_W'(mag_q) << 1)
		+ SUM_W'(byte_s1[3:0]);
	assign mag_clamp = (mag_sum > SUM_W'(MAG_MAX));

	// signed value of the open field
	assign mag_ext    = VALUE_BITS'(mag_q);
	assign signed_val = neg_q ? (VALUE_BITS'(0) - mag_ext) : mag_ext;

	// per-byte update
	always_comb begin
		mag_n       = mag_q;
		neg_n       = neg_q;
		open_n      = open_q;
		count_n     = count_q;
		clamp_n     = clamp_q;
		ovf_n       = ovf_q;
		res_valid   = 1'b0;
		res_present = kept;
		res_last    = 1'b0;
		res_dropped = ovf_q;
		res_sat     = kept && clamp_q;
		res_value   = kept ? signed_val : '0;
		res_index   = kept ? idx_full[INDEX_W-1:0] : '0;
		if (is_nl) begin
			res_valid = 1'b1;
			res_last  = 1'b1;
			mag_n     = '0;
			neg_n     = 1'b0;
			open_n    = 1'b0;
			count_n   = '0;
			clamp_n   = 1'b0;
			ovf_n     = 1'b0;
		end else if (is_sign) begin
			res_valid   = kept;
			ovf_n       = ovf_q || (cnt_inc_ext > eff_lim);
			res_dropped = ovf_n;
			count_n     = cnt_inc;
			neg_n       = (byte_s1 == CH_MINUS);
			mag_n       = '0;
			clamp_n     = 1'b0;
			open_n      = 1'b1;
		end else if (is_digit) begin
			if (open_q) begin
				if (mag_clamp) begin
					mag_n   = MAG_MAX;
					clamp_n = 1'b1;
				end else begin
					mag_n = mag_sum[MAG_W-1:0];
				end
			end
		end else begin
			mag_n   = '0;
			clamp_n = 1'b0;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			field_limit_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q   <= '0;
			neg_q   <= 1'b0;
			open_q  <= 1'b0;
			count_q <= '0;
			clamp_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (fire) begin
			mag_q   <= mag_n;
			neg_q   <= neg_n;
			open_q  <= open_n;
			count_q <= count_n;
			clamp_q <= clamp_n;
			ovf_q   <= ovf_n;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= fire && res_valid;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (out_free && fire && res_valid) begin
			field_value     <= res_value;
			field_index     <= res_index;
			field_present   <= res_present;
			last_in_line    <= res_last;
			fields_dropped  <= res_dropped;
			value_saturated <= res_sat;
		end
	end

endmodule

`default_nettype wire

>>> src/sdlp_checker.sv
// port-level checks for the signed decimal line parser, with bind
`default_nettype none

`include "assert_macros.svh"

module sdlp_checker #(
	parameter int VALUE_BITS = sdlp_pkg::VALUE_BITS_DEF
) (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          out_valid,
	input wire                          out_ready,
	input wire [VALUE_BITS-1:0]         field_value,
	input wire [sdlp_pkg::INDEX_W-1:0]  field_index,
	input wire                          field_present,
	input wire                          last_in_line,
	input wire                          value_saturated
);
	import sdlp_pkg::*;

	localparam logic [VALUE_BITS-1:0] MOST_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};

	// a stalled result word holds
	`SDLP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(field_value) && $stable(last_in_line))

	// an empty word only ends a line, with zero value and index
	`SDLP_ASSERT_NOW(a_empty_is_eol, clk, arst_n, out_valid && !field_present, last_in_line && (field_value == '0) && (field_index == '0))

	// saturation is only reported on a real field
	`SDLP_ASSERT_NOW(a_sat_needs_field, clk, arst_n, out_valid && value_saturated, field_present)

	// magnitudes clamp symmetrically, so the most negative code never shows
	`SDLP_ASSERT_NOW(a_no_most_neg, clk, arst_n, out_valid, field_value != MOST_NEG)

endmodule

bind signed_decimal_line_parser sdlp_checker #(
	.VALUE_BITS(VALUE_BITS)
) u_sdlp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.field_value    (field_value),
	.field_index    (field_index),
	.field_present  (field_present),
	.last_in_line   (last_in_line),
	.value_saturated(value_saturated)
);

`default_nettype wire
